// ----- sv/mgd_pkg.sv -----
package mgd_pkg;

    localparam int MAX_ROWS   = 32;
    localparam int MAX_COLS   = 32;
    localparam int GRID_CELLS = MAX_ROWS * MAX_COLS;
    localparam int SIZE_LIM_ROWS = (MAX_ROWS < 32) ? MAX_ROWS : 32;
    localparam int SIZE_LIM_COLS = (MAX_COLS < 32) ? MAX_COLS : 32;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 5;
    localparam int SIZE_W  = 6;
    localparam int CELL_AW = $clog2(GRID_CELLS);
    localparam int STK_AW  = CELL_AW;
    localparam int STK_CW  = $clog2(GRID_CELLS + 1);

    localparam logic [1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [1:0] CFG_COL_COUNT = 2'd1;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_STEP  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_S = 2'd1,
        DIR_E = 2'd2,
        DIR_W = 2'd3
    } dir_t;

    localparam logic [2:0] DIR_NONE    = 3'd4;
    localparam logic [7:0] ORDER_RESET = {DIR_E, DIR_S, DIR_W, DIR_N};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_CARVE,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       visited;
        logic [3:0] openings;
    } cell_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } stk_entry_t;

    typedef struct packed {
        logic               we;
        logic [CELL_AW-1:0] waddr;
        cell_t              wdata;
        logic               re_a;
        logic [CELL_AW-1:0] raddr_a;
        logic               re_b;
        logic [CELL_AW-1:0] raddr_b;
    } cell_req_t;

    typedef struct packed {
        logic              we;
        logic [STK_AW-1:0] waddr;
        stk_entry_t        wdata;
        logic              re;
        logic [STK_AW-1:0] raddr;
    } stk_req_t;

    typedef struct packed {
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic [2:0]       carved_dir;
        logic             done_res;
        logic [3:0]       openings;
        logic             visited;
    } result_t;

    typedef struct packed {
        logic             ok;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } nbr_t;

    function automatic logic [CELL_AW-1:0] cell_addr(logic [ROW_W-1:0] r,
                                                     logic [COL_W-1:0] c);
        return CELL_AW'((int'(r) % MAX_ROWS) * MAX_COLS + (int'(c) % MAX_COLS));
    endfunction

endpackage

// ----- sv/mgd_cell_ram.sv -----
module mgd_cell_ram
    import mgd_pkg::*;
(
    input  logic      aclk,
    input  cell_req_t req,
    output cell_t     rdata_a,
    output cell_t     rdata_b
);

    cell_t mem [GRID_CELLS];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re_a) begin
            rdata_a <= mem[req.raddr_a];
        end
        if (req.re_b) begin
            rdata_b <= mem[req.raddr_b];
        end
    end

endmodule

// ----- sv/mgd_stack_ram.sv -----
module mgd_stack_ram
    import mgd_pkg::*;
(
    input  logic       aclk,
    input  stk_req_t   req,
    output stk_entry_t rdata
);

    stk_entry_t mem [GRID_CELLS];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

// ----- sv/mgd_ctrl.sv -----
module mgd_ctrl
    import mgd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [7:0]        s_rand_picks,
    input  logic [ROW_W-1:0]  s_row,
    input  logic [COL_W-1:0]  s_col,
    input  logic [SIZE_W-1:0] rows,
    input  logic [SIZE_W-1:0] cols,
    input  logic              out_free,
    output logic              res_load,
    output result_t           res,
    output cell_req_t         cell_req,
    input  cell_t             cell_rdata_a,
    input  cell_t             cell_rdata_b,
    output stk_req_t          stk_req,
    input  stk_entry_t        stk_rdata
);

    state_t             state_reg, state_next;
    logic [CELL_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic               clr_start_reg, clr_start_next;
    logic [7:0]         order_reg, order_next;
    logic [STK_CW-1:0]  count_reg, count_next;
    logic [1:0]         k_reg, k_next;
    stk_entry_t         cur_reg, cur_next;
    nbr_t               nbr_reg, nbr_next;
    dir_t               dir_reg, dir_next;
    result_t            res_reg, res_next;

    function automatic logic [7:0] shuffle_order(logic [7:0] ord, logic [7:0] picks);
        logic [7:0] v;
        logic [1:0] s;
        logic [1:0] a;
        logic [1:0] b;
        v = ord;
        for (int i = 0; i < 4; i++) begin
            s = picks[2*i +: 2];
            a = v[2*i +: 2];
            b = v[2*s +: 2];
            v[2*i +: 2] = b;
            v[2*s +: 2] = a;
        end
        return v;
    endfunction

    function automatic nbr_t nbr_of(stk_entry_t p, dir_t d,
                                    logic [SIZE_W-1:0] nrows, logic [SIZE_W-1:0] ncols);
        nbr_t n;
        n.ok  = 1'b0;
        n.row = p.row;
        n.col = p.col;
        case (d)
            DIR_N: begin
                n.ok  = (p.row != '0);
                n.row = p.row - ROW_W'(1);
            end
            DIR_S: begin
                n.ok  = ({1'b0, p.row} + SIZE_W'(1)) < nrows;
                n.row = p.row + ROW_W'(1);
            end
            DIR_E: begin
                n.ok  = ({1'b0, p.col} + SIZE_W'(1)) < ncols;
                n.col = p.col + COL_W'(1);
            end
            DIR_W: begin
                n.ok  = (p.col != '0);
                n.col = p.col - COL_W'(1);
            end
            default: begin
                n.ok = 1'b0;
            end
        endcase
        return n;
    endfunction

    function automatic logic [3:0] dir_bit(dir_t d);
        return 4'b0001 << d;
    endfunction

    function automatic logic [3:0] back_bit(dir_t d);
        logic [3:0] b;
        case (d)
            DIR_N:   b = dir_bit(DIR_S);
            DIR_S:   b = dir_bit(DIR_N);
            DIR_E:   b = dir_bit(DIR_W);
            DIR_W:   b = dir_bit(DIR_E);
            default: b = '0;
        endcase
        return b;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_start_reg <= 1'b0;
            order_reg     <= ORDER_RESET;
            count_reg     <= '0;
            k_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_start_reg <= clr_start_next;
            order_reg     <= order_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        nbr_reg <= nbr_next;
        dir_reg <= dir_next;
        res_reg <= res_next;
    end

    always_comb begin
        logic [STK_CW-1:0] cnt_dec;
        dir_t              d_cur;
        dir_t              d_nxt;
        nbr_t              n_cur;
        nbr_t              n_nxt;
        nbr_t              n_first;
        cell_t             here_new;
        logic [1:0]        k_inc;

        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_start_next = clr_start_reg;
        order_next     = order_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        nbr_next       = nbr_reg;
        dir_next       = dir_reg;
        res_next       = res_reg;
        cell_req       = '0;
        stk_req        = '0;
        s_ready        = 1'b0;
        res_load       = 1'b0;

        cnt_dec  = count_reg - STK_CW'(1);
        k_inc    = k_reg + 2'd1;
        d_cur    = dir_t'(order_reg[2*k_reg +: 2]);
        d_nxt    = dir_t'(order_reg[2*k_inc +: 2]);
        n_cur    = nbr_of(cur_reg, d_cur, rows, cols);
        n_nxt    = nbr_of(cur_reg, d_nxt, rows, cols);
        n_first  = nbr_of(stk_rdata, dir_t'(order_reg[1:0]), rows, cols);
        here_new = cell_rdata_a;
        here_new.visited = 1'b1;

        case (state_reg)
            ST_CLEAR: begin
                cell_req.we    = 1'b1;
                cell_req.waddr = clr_cnt_reg;
                cell_req.wdata = '0;
                if (clr_start_reg && clr_cnt_reg == '0) begin
                    cell_req.wdata.visited = 1'b1;
                end
                clr_cnt_next = clr_cnt_reg + CELL_AW'(1);
                if (clr_cnt_reg == CELL_AW'(GRID_CELLS - 1)) begin
                    state_next = clr_start_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                res_next.cell_row   = '0;
                res_next.cell_col   = '0;
                res_next.carved_dir = DIR_NONE;
                res_next.done_res   = 1'b0;
                res_next.openings   = '0;
                res_next.visited    = 1'b0;
                if (s_valid) begin
                    case (func_t'(s_func))
                        FUNC_START: begin
                            order_next       = ORDER_RESET;
                            count_next       = STK_CW'(1);
                            stk_req.we       = 1'b1;
                            stk_req.waddr    = '0;
                            stk_req.wdata    = '0;
                            clr_cnt_next     = '0;
                            clr_start_next   = 1'b1;
                            res_next.visited = 1'b1;
                            state_next       = ST_CLEAR;
                        end
                        FUNC_STEP: begin
                            if (count_reg != '0) begin
                                order_next    = shuffle_order(order_reg, s_rand_picks);
                                count_next    = cnt_dec;
                                stk_req.re    = 1'b1;
                                stk_req.raddr = cnt_dec[STK_AW-1:0];
                                state_next    = ST_POP;
                            end else begin
                                state_next = ST_OUT;
                            end
                        end
                        FUNC_READ: begin
                            cell_req.re_a     = 1'b1;
                            cell_req.raddr_a  = cell_addr(s_row, s_col);
                            res_next.cell_row = s_row;
                            res_next.cell_col = s_col;
                            state_next        = ST_READ;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_POP: begin
                cur_next         = stk_rdata;
                k_next           = '0;
                cell_req.re_a    = 1'b1;
                cell_req.raddr_a = cell_addr(stk_rdata.row, stk_rdata.col);
                cell_req.re_b    = 1'b1;
                cell_req.raddr_b = cell_addr(n_first.row, n_first.col);
                state_next       = ST_SCAN;
            end
            ST_SCAN: begin
                res_next.cell_row = cur_reg.row;
                res_next.cell_col = cur_reg.col;
                res_next.visited  = 1'b1;
                if (n_cur.ok && !cell_rdata_b.visited) begin
                    here_new.openings   = cell_rdata_a.openings | dir_bit(d_cur);
                    cell_req.we         = 1'b1;
                    cell_req.waddr      = cell_addr(cur_reg.row, cur_reg.col);
                    cell_req.wdata      = here_new;
                    if (count_reg < STK_CW'(GRID_CELLS)) begin
                        stk_req.we    = 1'b1;
                        stk_req.waddr = count_reg[STK_AW-1:0];
                        stk_req.wdata = cur_reg;
                        count_next    = count_reg + STK_CW'(1);
                    end
                    nbr_next            = n_cur;
                    dir_next            = d_cur;
                    res_next.carved_dir = {1'b0, d_cur};
                    res_next.openings   = here_new.openings;
                    state_next          = ST_CARVE;
                end else if (k_reg == 2'd3) begin
                    cell_req.we         = 1'b1;
                    cell_req.waddr      = cell_addr(cur_reg.row, cur_reg.col);
                    cell_req.wdata      = here_new;
                    res_next.carved_dir = DIR_NONE;
                    res_next.openings   = cell_rdata_a.openings;
                    state_next          = ST_OUT;
                end else begin
                    k_next           = k_inc;
                    cell_req.re_b    = 1'b1;
                    cell_req.raddr_b = cell_addr(n_nxt.row, n_nxt.col);
                end
            end
            ST_CARVE: begin
                cell_req.we             = 1'b1;
                cell_req.waddr          = cell_addr(nbr_reg.row, nbr_reg.col);
                cell_req.wdata          = cell_rdata_b;
                cell_req.wdata.openings = cell_rdata_b.openings | back_bit(dir_reg);
                if (count_reg < STK_CW'(GRID_CELLS)) begin
                    stk_req.we        = 1'b1;
                    stk_req.waddr     = count_reg[STK_AW-1:0];
                    stk_req.wdata.row = nbr_reg.row;
                    stk_req.wdata.col = nbr_reg.col;
                    count_next        = count_reg + STK_CW'(1);
                end
                state_next = ST_OUT;
            end
            ST_READ: begin
                res_next.openings = cell_rdata_a.openings;
                res_next.visited  = cell_rdata_a.visited;
                state_next        = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res          = res_reg;
        res.done_res = (count_reg == '0);
    end

endmodule

// ----- sv/maze_generator_dfs.sv -----
// Depth-first maze generator.
// Input channel s_*: one item per transfer; s_func selects start, step, read
// or no operation. Result channel m_*: exactly one result per input item, in
// order. Configuration channel cfg_*: cfg_index 0 writes the row count, 1 the
// column count; other indexes are ignored. cfg_ready is always high.
// Work from input transfer to result valid:
//   read: cell read, then output; no operation, or step on an empty stack:
//   output only; step: pop, then neighbors probed one at a time (up to four)
//   on the second read port of the cell memory, then carve if one is open,
//   then output; start: a pass that clears all 1024 cell entries one per
//   cycle through the single write port, marking cell 0 visited, then output.
// One item is in work at a time; the next is taken once the current result
// sits in the output register, so a stalled receiver holds at most one
// finished result while one more item is worked on.
// Reset: the stack empties, the direction order returns to N,W,S,E, the
// sizes return to 7 rows by 2 columns, and a pass zeroes the cell
// memory while s_ready stays low.
module maze_generator_dfs
    import mgd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [7:0]        s_rand_picks,
    input  logic [ROW_W-1:0]  s_row,
    input  logic [COL_W-1:0]  s_col,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [ROW_W-1:0]  m_cell_row,
    output logic [COL_W-1:0]  m_cell_col,
    output logic [2:0]        m_carved_dir,
    output logic              m_done_res,
    output logic [3:0]        m_openings,
    output logic              m_visited,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [SIZE_W-1:0] cfg_data
);

    logic [SIZE_W-1:0] row_count_reg, row_count_next;
    logic [SIZE_W-1:0] col_count_reg, col_count_next;
    logic [SIZE_W-1:0] rows, cols;
    logic              m_valid_reg, m_valid_next;
    result_t           out_reg;
    logic              out_free;
    logic              res_load;
    result_t           res;
    cell_req_t         cell_req;
    cell_t             cell_rdata_a, cell_rdata_b;
    stk_req_t          stk_req;
    stk_entry_t        stk_rdata;

    assign cfg_ready = 1'b1;

    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ROW_COUNT: row_count_next = cfg_data;
                CFG_COL_COUNT: col_count_next = cfg_data;
                default: begin
                    row_count_next = row_count_reg;
                end
            endcase
        end
    end

    always_comb begin
        if (row_count_reg == '0) begin
            rows = SIZE_W'(1);
        end else if (row_count_reg > SIZE_W'(SIZE_LIM_ROWS)) begin
            rows = SIZE_W'(SIZE_LIM_ROWS);
        end else begin
            rows = row_count_reg;
        end
        if (col_count_reg == '0) begin
            cols = SIZE_W'(1);
        end else if (col_count_reg > SIZE_W'(SIZE_LIM_COLS)) begin
            cols = SIZE_W'(SIZE_LIM_COLS);
        end else begin
            cols = col_count_reg;
        end
    end

    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid_next = res_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= SIZE_W'(7);
            col_count_reg <= SIZE_W'(2);
            m_valid_reg   <= 1'b0;
        end else begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_row   = out_reg.cell_row;
    assign m_cell_col   = out_reg.cell_col;
    assign m_carved_dir = out_reg.carved_dir;
    assign m_done_res   = out_reg.done_res;
    assign m_openings   = out_reg.openings;
    assign m_visited    = out_reg.visited;

    mgd_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_rand_picks (s_rand_picks),
        .s_row        (s_row),
        .s_col        (s_col),
        .rows         (rows),
        .cols         (cols),
        .out_free     (out_free),
        .res_load     (res_load),
        .res          (res),
        .cell_req     (cell_req),
        .cell_rdata_a (cell_rdata_a),
        .cell_rdata_b (cell_rdata_b),
        .stk_req      (stk_req),
        .stk_rdata    (stk_rdata)
    );

    mgd_cell_ram u_cell_ram (
        .aclk    (aclk),
        .req     (cell_req),
        .rdata_a (cell_rdata_a),
        .rdata_b (cell_rdata_b)
    );

    mgd_stack_ram u_stack_ram (
        .aclk  (aclk),
        .req   (stk_req),
        .rdata (stk_rdata)
    );

endmodule

// ----- sv/mgd_checker.sv -----
module mgd_checker
    import mgd_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [ROW_W-1:0] m_cell_row,
    input logic [COL_W-1:0] m_cell_col,
    input logic [2:0]       m_carved_dir,
    input logic             m_done_res,
    input logic [3:0]       m_openings,
    input logic             m_visited
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_row) && $stable(m_cell_col)
            && $stable(m_carved_dir) && $stable(m_openings))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken during memory clear");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    a_carve_visited: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_carved_dir != DIR_NONE |-> m_visited && !m_done_res
            && m_openings[m_carved_dir[1:0]])
        else $error("carved passage without matching opening");

endmodule

bind maze_generator_dfs mgd_checker u_mgd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_cell_row   (m_cell_row),
    .m_cell_col   (m_cell_col),
    .m_carved_dir (m_carved_dir),
    .m_done_res   (m_done_res),
    .m_openings   (m_openings),
    .m_visited    (m_visited)
);
